// ===== sv/thc_pkg.sv =====
// Shared types, constants and the octal digit step for the tar header checker.
package thc_pkg;

	localparam int unsigned BlockLen = 512;
	localparam int unsigned PosW     = $clog2(BlockLen);

	localparam logic [PosW-1:0] SizeOff  = PosW'(124);
	localparam logic [PosW-1:0] SizeLast = PosW'(135);
	localparam logic [PosW-1:0] ChkOff   = PosW'(148);
	localparam logic [PosW-1:0] ChkLast  = PosW'(155);
	localparam logic [PosW-1:0] TypeOff  = PosW'(156);
	localparam logic [PosW-1:0] MagicOff = PosW'(257);
	localparam logic [PosW-1:0] MagicEnd = PosW'(261);
	localparam logic [PosW-1:0] LeadLast = PosW'(4);
	localparam logic [PosW-1:0] LastPos  = PosW'(BlockLen - 1);

	localparam logic [4:0][7:0] MagicText = {8'h72, 8'h61, 8'h74, 8'h73, 8'h75};

	typedef enum logic [2:0] {
		ST_GOOD       = 3'd0,
		ST_END_BLOCK  = 3'd1,
		ST_COMPRESSED = 3'd2,
		ST_NO_MAGIC   = 3'd3,
		ST_BAD_SUM    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_GZIP  = 3'd1,
		KIND_BZIP2 = 3'd2,
		KIND_XZ    = 3'd3,
		KIND_ZSTD  = 3'd4,
		KIND_ZIP   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       first_block;
	} hdr_t;

	typedef struct packed {
		status_t     status;
		kind_t       compressed_kind;
		logic [63:0] member_size;
		logic [7:0]  member_type;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] value;
	} octal_t;

	function automatic octal_t octal_step(phase_t phase, logic [63:0] v, logic [7:0] b);
		octal_t r;
		logic   digit;
		digit   = (b >= 8'h30) && (b <= 8'h37);
		r.phase = phase;
		r.value = v;
		case (phase)
			PH_SKIP: begin
				if (b == 8'h20 || b == 8'h00) begin
					r.phase = PH_SKIP;
				end else if (digit) begin
					r.phase = PH_DIGITS;
					r.value = {61'd0, b[2:0]};
				end else begin
					r.phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (digit) begin
					r.value = {v[60:0], b[2:0]};
				end else begin
					r.phase = PH_DONE;
				end
			end
			default: r.phase = phase;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/thc_accum.sv =====
// Per-byte header state: position, sums, field parsing and the final verdict.
module thc_accum
	import thc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  hdr_t       hdr_s1,
	output logic       last,
	output res_t       res
);

	logic [PosW-1:0]    pos_q;
	logic [16:0]        usum_q, usum_d;
	logic signed [17:0] ssum_q, ssum_d;
	logic               zero_q, zero_d;
	logic               magic_q, magic_d;
	logic [4:0][7:0]    lead_q, lead_d;
	logic               first_q, first_d;
	logic [23:0]        chk_q, chk_d;
	phase_t             chk_ph_q, chk_ph_d;
	logic [63:0]        size_q, size_d;
	phase_t             size_ph_q, size_ph_d;
	logic               bin_q, bin_d;
	logic [7:0]         type_q, type_d;

	logic [7:0]      b;
	logic [7:0]      s;
	logic [PosW-1:0] moff;
	logic            in_chk;
	logic            in_size;
	octal_t          chk_o;
	octal_t          size_o;
	kind_t           kind;
	logic            sum_ok;

	assign b       = hdr_s1.header_byte;
	assign last    = (pos_q == LastPos);
	assign in_chk  = (pos_q >= ChkOff) && (pos_q <= ChkLast);
	assign in_size = (pos_q >= SizeOff) && (pos_q <= SizeLast);
	assign moff    = pos_q - MagicOff;
	assign s       = in_chk ? 8'h20 : b;
	assign chk_o   = octal_step(chk_ph_q, {40'd0, chk_q}, b);
	assign size_o  = octal_step(size_ph_q, size_q, b);

	always_comb begin
		usum_d    = usum_q + {9'd0, s};
		ssum_d    = ssum_q + {{10{s[7]}}, s};
		zero_d    = zero_q && (b == 8'h00);
		magic_d   = magic_q;
		lead_d    = lead_q;
		first_d   = first_q;
		chk_d     = chk_q;
		chk_ph_d  = chk_ph_q;
		size_d    = size_q;
		size_ph_d = size_ph_q;
		bin_d     = bin_q;
		type_d    = type_q;
		if (pos_q == '0) begin
			first_d = hdr_s1.first_block;
		end
		if (pos_q <= LeadLast) begin
			lead_d[pos_q[2:0]] = b;
		end
		if (pos_q >= MagicOff && pos_q <= MagicEnd && b != MagicText[moff[2:0]]) begin
			magic_d = 1'b0;
		end
		if (pos_q == TypeOff) begin
			type_d = b;
		end
		if (in_size) begin
			if (pos_q == SizeOff && b[7]) begin
				bin_d  = 1'b1;
				size_d = {57'd0, b[6:0]};
			end else if (bin_q) begin
				size_d = {size_q[55:0], b};
			end else begin
				size_d    = size_o.value;
				size_ph_d = size_o.phase;
			end
		end
		if (in_chk) begin
			chk_d    = chk_o.value[23:0];
			chk_ph_d = chk_o.phase;
		end
	end

	always_comb begin
		kind = KIND_NONE;
		if (first_d) begin
			if (lead_d[0] == 8'h1F && lead_d[1] == 8'h8B) begin
				kind = KIND_GZIP;
			end else if (lead_d[0] == 8'h42 && lead_d[1] == 8'h5A && lead_d[2] == 8'h68) begin
				kind = KIND_BZIP2;
			end else if (lead_d[0] == 8'hFD && lead_d[1] == 8'h37 && lead_d[2] == 8'h7A &&
			             lead_d[3] == 8'h58 && lead_d[4] == 8'h5A) begin
				kind = KIND_XZ;
			end else if (lead_d[0] == 8'h28 && lead_d[1] == 8'hB5 && lead_d[2] == 8'h2F &&
			             lead_d[3] == 8'hFD) begin
				kind = KIND_ZSTD;
			end else if (lead_d[0] == 8'h50 && lead_d[1] == 8'h4B) begin
				kind = KIND_ZIP;
			end
		end
	end

	assign sum_ok = (chk_d == {7'd0, usum_d}) ||
	                (!ssum_d[17] && chk_d == {6'd0, ssum_d});

	always_comb begin
		res.status          = ST_GOOD;
		res.compressed_kind = KIND_NONE;
		res.member_size     = size_d;
		res.member_type     = type_d;
		if (zero_d) begin
			res.status = ST_END_BLOCK;
		end else if (kind != KIND_NONE) begin
			res.status          = ST_COMPRESSED;
			res.compressed_kind = kind;
		end else if (!magic_d) begin
			res.status = ST_NO_MAGIC;
		end else if (!sum_ok) begin
			res.status = ST_BAD_SUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			usum_q    <= '0;
			ssum_q    <= '0;
			zero_q    <= 1'b1;
			magic_q   <= 1'b1;
			lead_q    <= '0;
			first_q   <= 1'b0;
			chk_q     <= '0;
			chk_ph_q  <= PH_SKIP;
			size_q    <= '0;
			size_ph_q <= PH_SKIP;
			bin_q     <= 1'b0;
			type_q    <= '0;
		end else if (step) begin
			if (last) begin
				pos_q     <= '0;
				usum_q    <= '0;
				ssum_q    <= '0;
				zero_q    <= 1'b1;
				magic_q   <= 1'b1;
				lead_q    <= '0;
				first_q   <= 1'b0;
				chk_q     <= '0;
				chk_ph_q  <= PH_SKIP;
				size_q    <= '0;
				size_ph_q <= PH_SKIP;
				bin_q     <= 1'b0;
				type_q    <= '0;
			end else begin
				pos_q     <= pos_q + 1'b1;
				usum_q    <= usum_d;
				ssum_q    <= ssum_d;
				zero_q    <= zero_d;
				magic_q   <= magic_d;
				lead_q    <= lead_d;
				first_q   <= first_d;
				chk_q     <= chk_d;
				chk_ph_q  <= chk_ph_d;
				size_q    <= size_d;
				size_ph_q <= size_ph_d;
				bin_q     <= bin_d;
				type_q    <= type_d;
			end
		end
	end

endmodule

// ===== sv/tar_header_checker_core.sv =====
// Top level of the tar header checker: input stage, header state and result register.
// Takes one header byte per cycle while the input stage is not stalled; bytes stream back to back, also across blocks.
// A result is registered when a block's byte 511 advances out of the input stage, one per 512 bytes.
// The input stage stalls only when the last byte meets a result register not yet taken.
// Reset clears position, sums and parse state; the block starts at byte 0 of a header.
module tar_header_checker_core
	import thc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic hdr_valid,
	output logic hdr_ready,
	input  hdr_t hdr,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic valid_s1;
	hdr_t hdr_s1;
	logic adv_s1;
	logic last;
	res_t res_c;
	logic res_valid_q;
	res_t res_q;

	thc_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.hdr_s1 (hdr_s1),
		.last   (last),
		.res    (res_c)
	);

	assign adv_s1    = valid_s1 && (!last || !res_valid_q || res_ready);
	assign hdr_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_valid && hdr_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_valid && hdr_ready) begin
			hdr_s1 <= hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last) begin
			res_q <= res_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/tar_header_checker_core_chk.sv =====
// Port-level assertions for the tar header checker and their bind.
module tar_header_checker_core_chk
	import thc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic hdr_valid,
	input logic hdr_ready,
	input hdr_t hdr,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	a_hdr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr))
		else $error("header transfer dropped or changed while waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_end_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_END_BLOCK |->
			res.member_size == 64'd0 && res.member_type == 8'd0 &&
			res.compressed_kind == KIND_NONE)
		else $error("end block carries nonzero fields");

	a_kind_only_compressed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_COMPRESSED |-> res.compressed_kind == KIND_NONE)
		else $error("compression kind without compressed status");

	a_compressed_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_COMPRESSED |-> res.compressed_kind != KIND_NONE)
		else $error("compressed status without kind");

endmodule

bind tar_header_checker_core tar_header_checker_core_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.hdr_valid (hdr_valid),
	.hdr_ready (hdr_ready),
	.hdr       (hdr),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the tar header checker: header blocks in, verdicts checked.
`timescale 1ns / 100ps

module tb_top;
	import thc_pkg::*;

	localparam int MODE_AT   = 100;
	localparam int UID_AT    = 108;
	localparam int GID_AT    = 116;
	localparam int SIZE_AT   = 124;
	localparam int MTIME_AT  = 136;
	localparam int CHK_AT    = 148;
	localparam int TYPE_AT   = 156;
	localparam int MAGIC_AT  = 257;
	localparam int PREFIX_AT = 345;
	localparam int LAST_AT   = 511;

	localparam logic [39:0] USTAR_TEXT   = "ustar";
	localparam logic [7:0]  TYPE_REGULAR = 8'h30;

	typedef enum int {SEAL_UNSIGNED, SEAL_SIGNED, SEAL_WRONG} seal_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic hdr_valid = 1'b0;
	logic hdr_ready;
	hdr_t hdr       = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	tar_header_checker_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr       (hdr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	logic [7:0] blk [512];

	res_t expected_verdicts [$];
	res_t oldest_verdict;
	int   mismatch_count   = 0;
	int   verdicts_checked = 0;
	int   bytes_sent       = 0;
	int   blocks_sent      = 0;
	int   status_seen [8];

	logic [8:0]        at_byte;
	logic [16:0]       sum_u;
	logic [17:0]       sum_s;
	bit                seen_nonzero;
	bit                magic_ok;
	logic [4:0][7:0]   lead5;
	bit                flag_first;
	logic [23:0]       chk_acc;
	phase_t            chk_ph;
	logic [63:0]       size_acc;
	phase_t            size_ph;
	bit                size_b256;
	logic [7:0]        type_flag;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic reset_prediction();
		at_byte      = '0;
		sum_u        = '0;
		sum_s        = '0;
		seen_nonzero = 1'b0;
		magic_ok     = 1'b1;
		lead5        = '0;
		flag_first   = 1'b0;
		chk_acc      = '0;
		chk_ph       = PH_SKIP;
		size_acc     = '0;
		size_ph      = PH_SKIP;
		size_b256    = 1'b0;
		type_flag    = '0;
	endtask

	task automatic octal_feed(inout phase_t ph, inout logic [63:0] acc, input logic [7:0] b);
		bit is_digit;
		is_digit = (b >= 8'h30) && (b <= 8'h37);
		case (ph)
			PH_SKIP: begin
				if (is_digit) begin
					ph  = PH_DIGITS;
					acc = 64'(b - 8'h30);
				end else if (b != 8'h20 && b != 8'h00) begin
					ph = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					acc = (acc << 3) | 64'(b - 8'h30);
				end else begin
					ph = PH_DONE;
				end
			end
			default: ;
		endcase
	endtask

	task automatic predict_header_byte(input hdr_t h);
		logic [7:0]  b;
		logic [7:0]  s;
		logic [63:0] acc;
		bit          sum_match;
		status_t     st;
		kind_t       k;
		res_t        r;
		b = h.header_byte;
		if (at_byte == 0) flag_first = h.first_block;
		if (b != 8'h00) seen_nonzero = 1'b1;
		if (at_byte < 5) lead5[at_byte] = b;
		if (at_byte >= MAGIC_AT && at_byte < MAGIC_AT + 5 &&
			b != USTAR_TEXT[8 * (4 - (at_byte - MAGIC_AT)) +: 8]) magic_ok = 1'b0;
		if (at_byte == TYPE_AT) type_flag = b;

		if (at_byte >= SIZE_AT && at_byte < SIZE_AT + 12) begin
			if (at_byte == SIZE_AT && b[7]) begin
				size_b256 = 1'b1;
				size_acc  = {57'd0, b[6:0]};
			end else if (size_b256) begin
				size_acc = {size_acc[55:0], b};
			end else begin
				octal_feed(size_ph, size_acc, b);
			end
		end

		s = b;
		if (at_byte >= CHK_AT && at_byte < CHK_AT + 8) begin
			acc = {40'd0, chk_acc};
			octal_feed(chk_ph, acc, b);
			chk_acc = acc[23:0];
			s       = 8'h20;
		end
		sum_u = sum_u + s;
		sum_s = sum_s + {{10{s[7]}}, s};

		if (at_byte != LAST_AT) begin
			at_byte = at_byte + 1'b1;
		end else begin
			sum_match = (chk_acc == 24'(sum_u)) || (!sum_s[17] && chk_acc == 24'(sum_s));
			k  = KIND_NONE;
			st = ST_GOOD;
			if (!seen_nonzero) begin
				st = ST_END_BLOCK;
			end else begin
				if (flag_first) begin
					if (lead5[0] == 8'h1F && lead5[1] == 8'h8B)
						k = KIND_GZIP;
					else if (lead5[0] == 8'h42 && lead5[1] == 8'h5A && lead5[2] == 8'h68)
						k = KIND_BZIP2;
					else if (lead5 == 40'h5A_587A_37FD)
						k = KIND_XZ;
					else if (lead5[3:0] == 32'hFD2F_B528)
						k = KIND_ZSTD;
					else if (lead5[0] == 8'h50 && lead5[1] == 8'h4B)
						k = KIND_ZIP;
				end
				if (k != KIND_NONE) st = ST_COMPRESSED;
				else if (!magic_ok) st = ST_NO_MAGIC;
				else if (!sum_match) st = ST_BAD_SUM;
			end
			r.status          = st;
			r.compressed_kind = k;
			r.member_size     = size_acc;
			r.member_type     = type_flag;
			expected_verdicts = {expected_verdicts, r};
			reset_prediction();
		end
	endtask

	task automatic compare_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: result with no expectation, expected none, actual status %0d",
					$time, res.status);
				mismatch_count++;
			end else begin
				oldest_verdict = expected_verdicts.pop_front();
				compare_field("status", oldest_verdict.status, res.status);
				compare_field("compressed_kind", oldest_verdict.compressed_kind,
					res.compressed_kind);
				compare_field("member_size", oldest_verdict.member_size, res.member_size);
				compare_field("member_type", oldest_verdict.member_type, res.member_type);
				verdicts_checked++;
				status_seen[res.status]++;
			end
		end
	end

	task automatic send_byte(input hdr_t h);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			hdr_valid <= 1'b0;
			@(negedge clk);
		end
		hdr_valid <= 1'b1;
		hdr       <= h;
		do @(posedge clk); while (!hdr_ready);
		predict_header_byte(h);
		bytes_sent++;
	endtask

	task automatic send_block(input bit first);
		hdr_t h;
		for (int i = 0; i < 512; i++) begin
			h.header_byte = blk[i];
			h.first_block = (i == 0) ? first : 1'($urandom_range(1));
			send_byte(h);
		end
		blocks_sent++;
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		hdr_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic store_octal(input int off, input int len, input int blanks,
		input logic [63:0] v, input bit term);
		int nd;
		nd = len - blanks - (term ? 1 : 0);
		for (int i = 0; i < blanks; i++) blk[off + i] = $urandom_range(1) ? 8'h20 : 8'h00;
		for (int i = 0; i < nd; i++)
			blk[off + blanks + i] = 8'h30 + 8'((v >> (3 * (nd - 1 - i))) & 64'h7);
		if (term) blk[off + len - 1] = $urandom_range(1) ? 8'h00 : 8'h20;
	endtask

	task automatic fill_header(input logic [63:0] size, input logic [7:0] flag);
		int name_len;
		foreach (blk[i]) blk[i] = 8'h00;
		name_len = $urandom_range(1, 99);
		for (int i = 0; i < name_len; i++) blk[i] = 8'($urandom_range(33, 126));
		store_octal(MODE_AT, 8, 0, 64'o644, 1'b1);
		store_octal(UID_AT, 8, 0, 64'($urandom_range(4095)), 1'b1);
		store_octal(GID_AT, 8, 0, 64'($urandom_range(4095)), 1'b1);
		store_octal(SIZE_AT, 12, 0, size, 1'b1);
		store_octal(MTIME_AT, 12, 0, 64'($urandom), 1'b1);
		blk[TYPE_AT] = flag;
		for (int k = 0; k < 5; k++) blk[MAGIC_AT + k] = USTAR_TEXT[8 * (4 - k) +: 8];
		blk[MAGIC_AT + 6] = 8'h30;
		blk[MAGIC_AT + 7] = 8'h30;
	endtask

	task automatic put_signature(input kind_t k);
		logic [39:0] sig;
		int          n;
		case (k)
			KIND_GZIP: begin
				sig = 40'h8B1F;
				n   = 2;
			end
			KIND_BZIP2: begin
				sig = 40'h68_5A42;
				n   = 3;
			end
			KIND_XZ: begin
				sig = 40'h5A_587A_37FD;
				n   = 5;
			end
			KIND_ZSTD: begin
				sig = 40'hFD2F_B528;
				n   = 4;
			end
			KIND_ZIP: begin
				sig = 40'h4B50;
				n   = 2;
			end
			default: begin
				sig = '0;
				n   = 0;
			end
		endcase
		for (int i = 0; i < n; i++) blk[i] = sig[8 * i +: 8];
	endtask

	task automatic seal_checksum(input seal_t how);
		int         total_u;
		int         total_s;
		int         v;
		int         blanks;
		bit         term;
		logic [7:0] x;
		total_u = 0;
		total_s = 0;
		for (int i = 0; i < 512; i++) begin
			x = (i >= CHK_AT && i < CHK_AT + 8) ? 8'h20 : blk[i];
			total_u += x;
			total_s += x[7] ? int'(x) - 256 : int'(x);
		end
		v = (how == SEAL_SIGNED && total_s >= 0) ? total_s : total_u;
		if (how == SEAL_WRONG) v += $urandom_range(1, 999);
		blanks = $urandom_range(1);
		term   = (blanks != 0) || ($urandom_range(3) != 0);
		store_octal(CHK_AT, 8, blanks, 64'(v), term);
	endtask

	task automatic test_end_blocks();
		foreach (blk[i]) blk[i] = 8'h00;
		send_block(1'b1);
		send_block(1'b0);
		blk[LAST_AT] = 8'hFF;
		send_block(1'b1);
	endtask

	task automatic test_compression();
		for (int k = KIND_GZIP; k <= KIND_ZIP; k++) begin
			fill_header(64'd1000, TYPE_REGULAR);
			put_signature(kind_t'(k));
			seal_checksum(SEAL_UNSIGNED);
			send_block(1'b1);
		end
		fill_header(64'd77, TYPE_REGULAR);
		put_signature(KIND_GZIP);
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b0);
		fill_header(64'd5, TYPE_REGULAR);
		put_signature(KIND_XZ);
		blk[4] = 8'h00;
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b1);
		fill_header(64'd9, TYPE_REGULAR);
		put_signature(KIND_ZSTD);
		blk[MAGIC_AT] = 8'h00;
		seal_checksum(SEAL_WRONG);
		send_block(1'b1);
	endtask

	task automatic test_magic_and_checksum();
		fill_header(64'd512, TYPE_REGULAR);
		blk[MAGIC_AT + 4] = 8'h52;
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b0);
		fill_header(64'd512, TYPE_REGULAR);
		blk[MAGIC_AT + 1] = 8'h00;
		seal_checksum(SEAL_WRONG);
		send_block(1'b0);
		fill_header(64'd3, TYPE_REGULAR);
		seal_checksum(SEAL_WRONG);
		send_block(1'b0);
		fill_header(64'd4, TYPE_REGULAR);
		for (int i = PREFIX_AT; i < PREFIX_AT + 20; i++) blk[i] = 8'hC0;
		seal_checksum(SEAL_SIGNED);
		send_block(1'b1);
		fill_header(64'd6, TYPE_REGULAR);
		for (int i = PREFIX_AT; i < PREFIX_AT + 80; i++) blk[i] = 8'h80;
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b0);
		fill_header(64'd6, TYPE_REGULAR);
		for (int i = PREFIX_AT; i < PREFIX_AT + 80; i++) blk[i] = 8'h80;
		seal_checksum(SEAL_WRONG);
		send_block(1'b0);
	endtask

	task automatic test_size_and_type();
		fill_header(64'd0, 8'h00);
		store_octal(SIZE_AT, 12, 3, 64'o1234567, 1'b1);
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b0);
		fill_header(64'd0, 8'hFF);
		for (int i = 0; i < 12; i++) blk[SIZE_AT + i] = 8'hFF;
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b0);
		fill_header(64'd0, 8'h35);
		blk[SIZE_AT] = 8'h80;
		for (int i = 1; i < 12; i++) blk[SIZE_AT + i] = 8'($urandom);
		seal_checksum(SEAL_SIGNED);
		send_block(1'b0);
		fill_header(64'd0, 8'h78);
		blk[SIZE_AT] = 8'h78;
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b0);
		fill_header(64'd0, TYPE_REGULAR);
		store_octal(SIZE_AT, 12, 0, 64'o7777_7777_7777, 1'b0);
		send_block(1'b0);
		fill_header(64'd0, TYPE_REGULAR);
		store_octal(SIZE_AT, 12, 0, 64'o7654_3210_7654, 1'b0);
		blk[SIZE_AT + 5] = 8'h38;
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b0);
		fill_header(64'd0, TYPE_REGULAR);
		for (int i = 0; i < 12; i++) blk[SIZE_AT + i] = i[0] ? 8'h20 : 8'h00;
		seal_checksum(SEAL_UNSIGNED);
		send_block(1'b1);
	endtask

	task automatic test_random_headers(input int src_pct, input int sink_pct, input int count);
		int         pick;
		int         span;
		int         seal_pick;
		bit         first;
		logic [7:0] flag;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (int n = 0; n < count; n++) begin
			pick  = $urandom_range(99);
			first = ($urandom_range(3) == 0);
			if (pick < 6) begin
				foreach (blk[i]) blk[i] = 8'h00;
			end else if (pick < 12) begin
				foreach (blk[i]) blk[i] = 8'($urandom);
			end else begin
				flag = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h30, 8'h37));
				fill_header({$urandom, $urandom} & 64'h1_FFFF_FFFF, flag);
				case ($urandom_range(3))
					0: ;
					1: store_octal(SIZE_AT, 12, $urandom_range(1, 4), {$urandom, $urandom}, 1'b1);
					2: begin
						blk[SIZE_AT] = 8'h80 | 8'($urandom);
						for (int i = 1; i < 12; i++) blk[SIZE_AT + i] = 8'($urandom);
					end
					default: begin
						for (int i = 0; i < 12; i++) blk[SIZE_AT + i] = 8'($urandom_range(8'h20, 8'h39));
					end
				endcase
				if ($urandom_range(1)) begin
					span = $urandom_range(150);
					for (int i = PREFIX_AT; i < PREFIX_AT + span; i++) blk[i] = 8'($urandom);
				end
				if (pick < 20) put_signature(kind_t'($urandom_range(KIND_GZIP, KIND_ZIP)));
				if ($urandom_range(9) == 0)
					blk[MAGIC_AT + $urandom_range(4)] ^= 8'(1 << $urandom_range(7));
				seal_pick = $urandom_range(99);
				if (seal_pick < 45) seal_checksum(SEAL_UNSIGNED);
				else if (seal_pick < 90) seal_checksum(SEAL_SIGNED);
				else seal_checksum(SEAL_WRONG);
				if ($urandom_range(9) == 0) blk[$urandom_range(LAST_AT)] = 8'($urandom);
			end
			send_block(first);
		end
	endtask

	initial begin
		reset_prediction();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct   = 20;
		sink_stall_pct = 20;
		test_end_blocks();
		test_compression();
		test_magic_and_checksum();
		test_size_and_type();
		hold_until_drained();

		test_random_headers(0, 0, 12);
		hold_until_drained();
		test_random_headers(88, 0, 12);
		test_random_headers(0, 88, 12);
		hold_until_drained();
		test_random_headers(6, 6, 12);
		hold_until_drained();

		$display("Streamed %0d header bytes in %0d blocks, %0d verdicts checked",
			bytes_sent, blocks_sent, verdicts_checked);
		$display("Verdicts: good %0d, end block %0d, compressed %0d, no magic %0d, bad sum %0d",
			status_seen[ST_GOOD], status_seen[ST_END_BLOCK], status_seen[ST_COMPRESSED],
			status_seen[ST_NO_MAGIC], status_seen[ST_BAD_SUM]);
		if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
